FILE: hdl/assert_macros.svh
// Assertion macros used by the top level of the 8-bit instruction executer.
// Depends on nothing; each macro expects signals clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/t8ie_pkg.sv
// Shared types, constants and address helpers for the 8-bit instruction executer.
// Depends on nothing.
package t8ie_pkg;

    localparam int MEM_DEPTH = 32;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // opcode byte
    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_ALU   = 8'hA0;
    localparam logic [7:0] OP_LDI_A = 8'hA1;
    localparam logic [7:0] OP_LDI_B = 8'hB1;
    localparam logic [7:0] OP_LDI_C = 8'hC1;
    localparam logic [7:0] OP_LDM_A = 8'hA2;
    localparam logic [7:0] OP_LDM_B = 8'hB2;
    localparam logic [7:0] OP_LDM_C = 8'hC2;
    localparam logic [7:0] OP_LDM_X = 8'hD2;
    localparam logic [7:0] OP_ST_A  = 8'hA4;
    localparam logic [7:0] OP_ST_B  = 8'hB4;
    localparam logic [7:0] OP_ST_C  = 8'hC4;

    // sub-opcodes of the ALU group (operand byte)
    localparam logic [7:0] ALU_MOV_AB = 8'h00;
    localparam logic [7:0] ALU_MOV_AC = 8'h01;
    localparam logic [7:0] ALU_ADC    = 8'h02;
    localparam logic [7:0] ALU_ADD    = 8'h03;
    localparam logic [7:0] ALU_SBB    = 8'h04;
    localparam logic [7:0] ALU_SUB    = 8'h05;

    typedef logic [ADDR_W-1:0] addr_t;

    // architectural register file
    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [15:0] x;
        logic        carry;
        logic        sign;
    } cpu_state_t;

    // data memory write request
    typedef struct packed {
        logic       en;
        addr_t      addr;
        logic [7:0] data;
    } store_req_t;

    // operand byte to memory address, modulo MEM_DEPTH, built at elaboration
    typedef addr_t wrap_tbl_t [256];

    function automatic wrap_tbl_t build_wrap();
        wrap_tbl_t tbl;
        for (int i = 0; i < 256; i++)
        begin
            tbl[i] = addr_t'(i % MEM_DEPTH);
        end
        return tbl;
    endfunction

    localparam wrap_tbl_t WRAP_TBL = build_wrap();

    function automatic addr_t wrap_addr(logic [7:0] v);
        return WRAP_TBL[v];
    endfunction

    function automatic addr_t next_addr(addr_t a);
        addr_t r;
        if (a == addr_t'(MEM_DEPTH - 1))
            r = '0;
        else
            r = a + addr_t'(1);
        return r;
    endfunction

endpackage

FILE: hdl/t8ie_mem.sv
// Data memory: one write port, two registered read ports, zero until written.
// Depends on t8ie_pkg.
module t8ie_mem
(
    input  logic               clk,
    input  logic               rst_n,
    input  t8ie_pkg::store_req_t wr,
    input  logic               rd_en,
    input  t8ie_pkg::addr_t    rd_addr0,
    input  t8ie_pkg::addr_t    rd_addr1,
    output logic [7:0]         rd_data0,
    output logic [7:0]         rd_data1
);

    logic [7:0]                     mem [t8ie_pkg::MEM_DEPTH];
    logic [t8ie_pkg::MEM_DEPTH-1:0] valid_reg;
    logic [7:0]                     rd0_reg;
    logic [7:0]                     rd1_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wr.en)
            valid_reg[wr.addr] <= 1'b1;
    end

    // write-first: a store landing on the same edge is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && wr.addr == rd_addr0)
                rd0_reg <= wr.data;
            else
                rd0_reg <= valid_reg[rd_addr0] ? mem[rd_addr0] : 8'h00;
            if (wr.en && wr.addr == rd_addr1)
                rd1_reg <= wr.data;
            else
                rd1_reg <= valid_reg[rd_addr1] ? mem[rd_addr1] : 8'h00;
        end
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

endmodule

FILE: hdl/t8ie_exec.sv
// Instruction decode and execute: next register state, store request, bad flag.
// Depends on t8ie_pkg.
module t8ie_exec
(
    input  t8ie_pkg::cpu_state_t cur,
    input  logic [7:0]           op,
    input  logic [7:0]           operand,
    input  logic [7:0]           mem_hi,
    input  logic [7:0]           mem_lo,
    output t8ie_pkg::cpu_state_t nxt,
    output t8ie_pkg::store_req_t st,
    output logic                 bad
);

    logic [8:0] adc_sum;
    logic [7:0] b_adj;

    assign adc_sum = {1'b0, cur.a} + {1'b0, cur.b} + {8'h00, cur.carry};
    // borrow applied to B before the compare
    assign b_adj   = cur.carry ? (cur.b - 8'd1) : cur.b;

    always_comb
    begin
        nxt     = cur;
        st.en   = 1'b0;
        st.addr = t8ie_pkg::wrap_addr(operand);
        st.data = cur.a;
        bad     = 1'b0;
        unique case (op)
            t8ie_pkg::OP_NOP:
            begin
            end
            t8ie_pkg::OP_ALU:
            begin
                unique case (operand)
                    t8ie_pkg::ALU_MOV_AB: nxt.a = cur.b;
                    t8ie_pkg::ALU_MOV_AC: nxt.a = cur.c;
                    t8ie_pkg::ALU_ADC:
                    begin
                        nxt.a     = adc_sum[7:0];
                        nxt.carry = adc_sum[8];
                    end
                    t8ie_pkg::ALU_ADD:    nxt.a = cur.a + cur.c;
                    t8ie_pkg::ALU_SBB:
                    begin
                        nxt.b = b_adj;
                        if (cur.a > b_adj)
                            nxt.carry = 1'b0;
                        else
                        begin
                            nxt.carry = 1'b1;
                            nxt.sign  = 1'b1;
                        end
                        nxt.a = cur.a - b_adj;
                    end
                    t8ie_pkg::ALU_SUB:    nxt.a = cur.a - cur.c;
                    default:              bad = 1'b1;
                endcase
            end
            t8ie_pkg::OP_LDI_A: nxt.a = operand;
            t8ie_pkg::OP_LDI_B: nxt.b = operand;
            t8ie_pkg::OP_LDI_C: nxt.c = operand;
            t8ie_pkg::OP_LDM_A: nxt.a = mem_hi;
            t8ie_pkg::OP_LDM_B: nxt.b = mem_hi;
            t8ie_pkg::OP_LDM_C: nxt.c = mem_hi;
            t8ie_pkg::OP_LDM_X: nxt.x = {mem_hi, mem_lo};
            t8ie_pkg::OP_ST_A:
            begin
                st.en   = 1'b1;
                st.data = cur.a;
            end
            t8ie_pkg::OP_ST_B:
            begin
                st.en   = 1'b1;
                st.data = cur.b;
            end
            t8ie_pkg::OP_ST_C:
            begin
                st.en   = 1'b1;
                st.data = cur.c;
            end
            default: bad = 1'b1;
        endcase
    end

endmodule

FILE: hdl/toy_8bit_instruction_execute.sv
// Top level of the 8-bit instruction executer: input stage, register state,
// result register. Depends on t8ie_pkg, t8ie_mem, t8ie_exec, assert_macros.svh.
//
// Usage:
//   Slave channel s_*: one request per instruction, op in s_tdata[7:0],
//   operand in s_tdata[15:8]. Master channel m_*: one result per request,
//   holding A, B, C, X and the flag byte after that instruction; m_tuser
//   flags an unrecognised instruction (state left untouched).
//   Pipeline: two register stages (input/memory-read stage, result register);
//   a request moves on into the result register once that register is free.
//   Throughput: one request per clock while m_tready is high; the data memory
//   reads both bytes a load may need in the same cycle the request is taken,
//   and a store from the instruction ahead is forwarded into that read.
//   Reset: A, B, C, X, carry and sign clear; the 32-byte memory reads as
//   zero via per-entry valid bits, so no clearing pass is needed and the
//   block takes requests as soon as reset is released.
//   Back-pressure: when m_tready is low the result is held; one further
//   request can still be taken into the input stage, after which s_tready
//   drops until the result register drains.
module toy_8bit_instruction_execute
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] op, [15:8] operand
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] reg_a, [15:8] reg_b, [23:16] reg_c,
                                   // [39:24] reg_x, [47:40] flag_byte
    output logic [0:0]  m_tuser    // [0] bad_opcode
);

    `include "assert_macros.svh"

    // input stage
    logic                 s1_valid_reg, s1_valid_next;
    logic [7:0]           op_reg;
    logic [7:0]           operand_reg;

    // architectural state
    t8ie_pkg::cpu_state_t state_reg;
    t8ie_pkg::cpu_state_t state_next;

    // result register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [47:0]          m_tdata_reg;
    logic                 bad_reg;

    logic                 accept;
    logic                 out_free;
    logic                 commit;
    logic                 exec_bad;
    t8ie_pkg::store_req_t exec_st;
    t8ie_pkg::store_req_t mem_wr;
    t8ie_pkg::addr_t      rd_addr0;
    t8ie_pkg::addr_t      rd_addr1;
    logic [7:0]           mem_hi;
    logic [7:0]           mem_lo;

    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // both bytes of a possible X load are fetched on acceptance
    assign rd_addr0 = t8ie_pkg::wrap_addr(s_tdata[15:8]);
    assign rd_addr1 = t8ie_pkg::next_addr(rd_addr0);

    // stores only take effect when the instruction retires
    always_comb
    begin
        mem_wr    = exec_st;
        mem_wr.en = exec_st.en && commit;
    end

    t8ie_mem u_mem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (mem_wr),
        .rd_en    (accept),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (mem_hi),
        .rd_data1 (mem_lo)
    );

    t8ie_exec u_exec
    (
        .cur     (state_reg),
        .op      (op_reg),
        .operand (operand_reg),
        .mem_hi  (mem_hi),
        .mem_lo  (mem_lo),
        .nxt     (state_next),
        .st      (exec_st),
        .bad     (exec_bad)
    );

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (commit)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (commit)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (commit)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= s_tdata[7:0];
            operand_reg <= s_tdata[15:8];
        end
        if (commit)
        begin
            m_tdata_reg <= {state_next.carry, state_next.sign, 6'b000000,
                            state_next.x, state_next.c, state_next.b, state_next.a};
            bad_reg     <= exec_bad;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = bad_reg;

    // sign flag is sticky until reset
    `ASSERT_NEXT(a_sign_sticky, state_reg.sign, state_reg.sign, "sign flag cleared")
    // an unrecognised instruction leaves the state as it was
    `ASSERT_NEXT(a_bad_no_change, commit && exec_bad, state_reg == $past(state_reg),
        "bad instruction changed state")
    // a retiring instruction always produces a result
    `ASSERT_NEXT(a_commit_result, commit, m_tvalid, "retired instruction gave no result")
    // full input stage behind a stalled result blocks new requests
    `ASSERT_IMPL(a_stall_blocks, s1_valid_reg && m_tvalid && !m_tready, !s_tready,
        "request taken while both stages full")

endmodule
